[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the translator checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[sv/ftpt_pkg.sv]
// ----------------------------------------------------------------------------
// ftpt_pkg
// Types, constants and helpers shared by the first-touch page translator.
// ----------------------------------------------------------------------------
package ftpt_pkg;

   localparam int ADDR_W            = 64;
   localparam int PAGE_W            = 58;
   localparam int LOG2_W            = 5;
   localparam int TABLE_ENTRIES_DEF = 256;

   localparam logic [LOG2_W-1:0] LOG2_MIN   = 5'd6;
   localparam logic [LOG2_W-1:0] LOG2_MAX   = 5'd30;
   localparam logic [LOG2_W-1:0] LOG2_RESET = 5'd12;
   localparam logic [PAGE_W-1:0] FIRST_PAGE = 58'd1;

   // Search word handed from cell to cell
   typedef struct packed {
      logic              active;
      logic              hit;
      logic [PAGE_W-1:0] vpn;
      logic [PAGE_W-1:0] ppn;
   } search_word_type;

   // Broadcast write of a new mapping into one cell
   typedef struct packed {
      logic              en;
      logic [PAGE_W-1:0] tag;
      logic [PAGE_W-1:0] ppn;
   } alloc_write_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } state_type;

   // Page size clamped to the supported range
   function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] raw);
      logic [LOG2_W-1:0] s;
      s = raw;
      if (s < LOG2_MIN) begin
         s = LOG2_MIN;
      end
      if (s > LOG2_MAX) begin
         s = LOG2_MAX;
      end
      return s;
   endfunction

endpackage

[sv/ftpt_cell.sv]
// ----------------------------------------------------------------------------
// ftpt_cell
// One translation table entry. Compares the passing search word against its
// tag and hands the word on to the next cell, registered.
// ----------------------------------------------------------------------------
module ftpt_cell #(
   parameter int CELL_IDX = 0,
   parameter int IDX_W    = 8,
   parameter int CNT_W    = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ftpt_pkg::search_word_type word_i,
   output ftpt_pkg::search_word_type word_o,
   input  logic [CNT_W-1:0]          used_count,
   input  ftpt_pkg::alloc_write_type alloc_write,
   input  logic [IDX_W-1:0]          alloc_idx
);

   logic [ftpt_pkg::PAGE_W-1:0] tag_ff;
   logic [ftpt_pkg::PAGE_W-1:0] ppn_ff;
   ftpt_pkg::search_word_type   word_ff;
   ftpt_pkg::search_word_type   word_in;
   logic                        live;
   logic                        match;

   // entries are filled in order, so the fill count says which are valid
   assign live  = CNT_W'(CELL_IDX) < used_count;
   assign match = word_i.active && !word_i.hit && live && (tag_ff == word_i.vpn);

   // first match along the chain wins
   always_comb begin
      word_in     = word_i;
      word_in.hit = word_i.hit || match;
      word_in.ppn = match ? ppn_ff : word_i.ppn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.active <= 1'b0;
      end else begin
         word_ff <= word_in;
      end
   end

   // entry storage, written by broadcast
   always_ff @(posedge clock) begin
      if (alloc_write.en && (alloc_idx == IDX_W'(CELL_IDX))) begin
         tag_ff <= alloc_write.tag;
         ppn_ff <= alloc_write.ppn;
      end
   end

   assign word_o = word_ff;

endmodule

[sv/ftpt_ctl.sv]
// ----------------------------------------------------------------------------
// ftpt_ctl
// Sequencer: takes a request word, launches it down the cell chain, forms
// the response from the chain tail and allocates a page on a miss while the table has room.
// ----------------------------------------------------------------------------
module ftpt_ctl #(
   parameter int TABLE_ENTRIES = ftpt_pkg::TABLE_ENTRIES_DEF,
   parameter int IDX_W         = $clog2(TABLE_ENTRIES),
   parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ftpt_pkg::ADDR_W-1:0]        req_virt_addr,
   input  logic                               csr_write_en,
   input  logic [ftpt_pkg::LOG2_W-1:0]        csr_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ftpt_pkg::ADDR_W-1:0]        rsp_phys_addr,
   output logic                               rsp_newly_allocated,
   output logic                               rsp_table_full,
   output ftpt_pkg::search_word_type          head_word,
   input  ftpt_pkg::search_word_type          tail_word,
   output logic [CNT_W-1:0]                   used_count,
   output ftpt_pkg::alloc_write_type          alloc_write,
   output logic [IDX_W-1:0]                   alloc_idx
);

   ftpt_pkg::state_type state_ff, state_in;

   logic [ftpt_pkg::LOG2_W-1:0] page_log2_ff;
   logic [ftpt_pkg::ADDR_W-1:0] va_ff, va_in;
   logic [ftpt_pkg::PAGE_W-1:0] vpn_ff, vpn_in;
   logic                        launch_ff;
   logic [CNT_W-1:0]            used_ff, used_in;
   logic [ftpt_pkg::PAGE_W-1:0] next_page_ff, next_page_in;
   logic                        hit_ff, hit_in;
   logic [ftpt_pkg::PAGE_W-1:0] hit_ppn_ff, hit_ppn_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ftpt_pkg::ADDR_W-1:0] rsp_phys_ff, rsp_phys_in;
   logic                        rsp_new_ff, rsp_new_in;
   logic                        rsp_full_ff, rsp_full_in;

   logic [ftpt_pkg::LOG2_W-1:0] sh;
   logic [ftpt_pkg::ADDR_W-1:0] shifted;
   logic [ftpt_pkg::ADDR_W-1:0] offset;
   logic [ftpt_pkg::PAGE_W-1:0] ppn_sel;
   logic                        full;
   logic                        rsp_free;
   logic                        accept;
   logic                        finish;
   logic                        alloc;

   // next state, datapath and outputs
   always_comb begin
      sh       = ftpt_pkg::clamp_log2(page_log2_ff);
      shifted  = req_virt_addr >> sh;
      offset   = va_ff & ((64'd1 << sh) - 64'd1);
      full     = (used_ff == CNT_W'(TABLE_ENTRIES));
      ppn_sel  = hit_ff ? hit_ppn_ff : next_page_ff;
      rsp_free = !rsp_valid_ff || !rsp_stall;
      accept   = 1'b0;
      finish   = 1'b0;
      state_in = state_ff;

      unique case (state_ff)
         ftpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               accept   = 1'b1;
               state_in = ftpt_pkg::ST_SEARCH;
            end
         end
         ftpt_pkg::ST_SEARCH: begin
            if (tail_word.active) begin
               state_in = ftpt_pkg::ST_FINISH;
            end
         end
         ftpt_pkg::ST_FINISH: begin
            if (rsp_free) begin
               finish   = 1'b1;
               state_in = ftpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ftpt_pkg::ST_IDLE;
         end
      endcase

      alloc = finish && !hit_ff && !full;

      // request capture
      va_in  = accept ? req_virt_addr : va_ff;
      vpn_in = accept ? shifted[ftpt_pkg::PAGE_W-1:0] : vpn_ff;

      // chain tail capture
      hit_in     = (state_ff == ftpt_pkg::ST_SEARCH && tail_word.active) ? tail_word.hit : hit_ff;
      hit_ppn_in = (state_ff == ftpt_pkg::ST_SEARCH && tail_word.active) ? tail_word.ppn
                                                                         : hit_ppn_ff;

      // allocation pointers
      used_in      = alloc ? used_ff + CNT_W'(1) : used_ff;
      next_page_in = alloc ? next_page_ff + ftpt_pkg::PAGE_W'(1) : next_page_ff;

      // response word
      rsp_valid_in = finish ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_phys_in  = rsp_phys_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      if (finish) begin
         if (!hit_ff && full) begin
            rsp_phys_in = '0;
            rsp_new_in  = 1'b0;
            rsp_full_in = 1'b1;
         end else begin
            rsp_phys_in = ({{(ftpt_pkg::ADDR_W - ftpt_pkg::PAGE_W){1'b0}}, ppn_sel} << sh)
                          + offset;
            rsp_new_in  = !hit_ff;
            rsp_full_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ftpt_pkg::ST_IDLE;
         page_log2_ff <= ftpt_pkg::LOG2_RESET;
         launch_ff    <= 1'b0;
         used_ff      <= '0;
         next_page_ff <= ftpt_pkg::FIRST_PAGE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= accept;
         used_ff      <= used_in;
         next_page_ff <= next_page_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            page_log2_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      va_ff       <= va_in;
      vpn_ff      <= vpn_in;
      hit_ff      <= hit_in;
      hit_ppn_ff  <= hit_ppn_in;
      rsp_phys_ff <= rsp_phys_in;
      rsp_new_ff  <= rsp_new_in;
      rsp_full_ff <= rsp_full_in;
   end

   // chain head: launched for one cycle after accept
   always_comb begin
      head_word.active = launch_ff;
      head_word.hit    = 1'b0;
      head_word.vpn    = vpn_ff;
      head_word.ppn    = '0;
   end

   assign alloc_write.en  = alloc;
   assign alloc_write.tag = vpn_ff;
   assign alloc_write.ppn = next_page_ff;
   assign alloc_idx       = used_ff[IDX_W-1:0];
   assign used_count      = used_ff;

   assign req_stall           = (state_ff != ftpt_pkg::ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phys_addr       = rsp_phys_ff;
   assign rsp_newly_allocated = rsp_new_ff;
   assign rsp_table_full      = rsp_full_ff;

endmodule

[sv/first_touch_page_translator_core.sv]
// ----------------------------------------------------------------------------
// first_touch_page_translator_core
// Virtual to physical page translation with first-touch allocation, built
// as a sequencer feeding a chain of table-entry cells.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              word
//   req_      in          req_valid / req_stall  req_virt_addr
//   rsp_      out         rsp_valid / rsp_stall  rsp_phys_addr, flags
//   csr_      in          csr_write_en           csr_write_data (page_size_log2)
//
// Between one accept and the next, the search word walks the cell chain
// one entry per cycle.
// One request is in flight at a time; a response may wait in its output
// register while the next request is accepted and searched.
// A stalled response holds its word; the sequencer waits for the slot.
// Synchronous active-high reset empties the table (fill count to zero).
// ----------------------------------------------------------------------------
module first_touch_page_translator_core #(
   parameter int TABLE_ENTRIES = ftpt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ftpt_pkg::ADDR_W-1:0] req_virt_addr,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ftpt_pkg::ADDR_W-1:0] rsp_phys_addr,
   output logic                        rsp_newly_allocated,
   output logic                        rsp_table_full,
   input  logic                        csr_write_en,
   input  logic [ftpt_pkg::LOG2_W-1:0] csr_write_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   ftpt_pkg::search_word_type chain_word [TABLE_ENTRIES+1];
   ftpt_pkg::alloc_write_type alloc_write;
   logic [IDX_W-1:0]          alloc_idx;
   logic [CNT_W-1:0]          used_count;

   // sequencer
   ftpt_ctl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_ctl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_virt_addr       (req_virt_addr),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phys_addr       (rsp_phys_addr),
      .rsp_newly_allocated (rsp_newly_allocated),
      .rsp_table_full      (rsp_table_full),
      .head_word           (chain_word[0]),
      .tail_word           (chain_word[TABLE_ENTRIES]),
      .used_count          (used_count),
      .alloc_write         (alloc_write),
      .alloc_idx           (alloc_idx)
   );

   // row of table-entry cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ftpt_cell #(
         .CELL_IDX (i),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .word_i      (chain_word[i]),
         .word_o      (chain_word[i+1]),
         .used_count  (used_count),
         .alloc_write (alloc_write),
         .alloc_idx   (alloc_idx)
      );
   end

endmodule

[sv/ftpt_checker.sv]
// ----------------------------------------------------------------------------
// ftpt_checker
// Port-level checks on the translator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ftpt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ftpt_pkg::ADDR_W-1:0] rsp_phys_addr,
   input logic                        rsp_newly_allocated,
   input logic                        rsp_table_full
);

   // one request in flight: an accept is followed by stall
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a full table gives address zero
   `ASSERT_SAME(a_full_zero, clock, reset, rsp_valid && rsp_table_full, rsp_phys_addr == '0)

   // a full table never allocates
   `ASSERT_SAME(a_full_no_alloc, clock, reset, rsp_valid, !(rsp_table_full && rsp_newly_allocated))

   // stalled response word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_phys_addr))

endmodule

bind first_touch_page_translator_core ftpt_checker u_ftpt_checker (.*);
